/* src/accel_limited_unicycle_rollout_assert.svh */
// Assertion macros shared by the checker of the rollout block.
// No dependencies.
`ifndef ACCEL_LIMITED_UNICYCLE_ROLLOUT_ASSERT_SVH
`define ACCEL_LIMITED_UNICYCLE_ROLLOUT_ASSERT_SVH

// Check a next-cycle consequence outside of reset.
`define ALUR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

// Check a next-cycle consequence with reset included.
`define ALUR_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

/* src/alur_pkg.sv */
`timescale 1ns / 1ps
// Package of the rollout block: payload types, sequencer states, register indexes,
// fixed-point constants and helper functions. No dependencies.
package alur_pkg;

  localparam int MAX_STEPS         = 64;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int TABLE_LEN         = 24;
  localparam int CORDIC_N = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;

  localparam logic signed [35:0] PI_Q16      = 36'sd205887;
  localparam logic        [35:0] TWO_PI_Q16  = 36'd411775;
  localparam logic signed [35:0] WRAP_OFS    = 36'sd6746521600; // 2*pi << 14
  localparam logic        [3:0]  WRAP_TOP    = 4'd14;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_heading;
    logic signed [31:0] start_linear;
    logic signed [31:0] start_angular;
    logic signed [31:0] target_linear;
    logic signed [31:0] target_angular;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [5:0]  point_index;
    logic               last_point;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_LIN_ACCEL, REG_ANG_ACCEL, REG_STEP_TIME, REG_STEP_COUNT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DV, ST_DW, ST_DWL, ST_WRAP, ST_EMIT, ST_CINIT, ST_CORD,
    ST_MVC, ST_MVCDT, ST_MVS, ST_MVSDT, ST_MWDT, ST_HW
  } state_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q30 = 36'sd843314857;
      5'd1:  atan_q30 = 36'sd497837830;
      5'd2:  atan_q30 = 36'sd263043837;
      5'd3:  atan_q30 = 36'sd133525159;
      5'd4:  atan_q30 = 36'sd67021687;
      5'd5:  atan_q30 = 36'sd33543515;
      5'd6:  atan_q30 = 36'sd16775851;
      5'd7:  atan_q30 = 36'sd8388438;
      5'd8:  atan_q30 = 36'sd4194283;
      5'd9:  atan_q30 = 36'sd2097149;
      5'd10: atan_q30 = 36'sd1048576;
      5'd11: atan_q30 = 36'sd524288;
      5'd12: atan_q30 = 36'sd262144;
      5'd13: atan_q30 = 36'sd131072;
      5'd14: atan_q30 = 36'sd65536;
      5'd15: atan_q30 = 36'sd32768;
      5'd16: atan_q30 = 36'sd16384;
      5'd17: atan_q30 = 36'sd8192;
      5'd18: atan_q30 = 36'sd4096;
      5'd19: atan_q30 = 36'sd2048;
      5'd20: atan_q30 = 36'sd1024;
      5'd21: atan_q30 = 36'sd512;
      5'd22: atan_q30 = 36'sd256;
      5'd23: atan_q30 = 36'sd128;
      default: atan_q30 = 36'sd0;
    endcase
  endfunction

  // Move v toward t by at most d, stop at t.
  function automatic logic signed [31:0] ramp(input logic signed [31:0] v,
                                              input logic signed [31:0] t,
                                              input logic [32:0] d);
    logic signed [33:0] vv, tt, dd, up, dn;
    vv = 34'(v);
    tt = 34'(t);
    dd = $signed({1'b0, d});
    up = vv + dd;
    dn = vv - dd;
    if (tt - vv >= 0) begin
      ramp = (up < tt) ? up[31:0] : t;
    end else begin
      ramp = (dn > tt) ? dn[31:0] : t;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] s);
    if (s > 35'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (s < -35'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = s[31:0];
    end
  endfunction

endpackage

/* src/accel_limited_unicycle_rollout.sv */
`timescale 1ns / 1ps
// Top level of the acceleration-limited unicycle rollout: sequencer, shared
// multiplier, CORDIC and heading wrap unit. Depends on alur_pkg.
//
// Usage:
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. cfg_ready
//   is always high; write only while no rollout is in flight. Indexes are
//   linear accel limit, angular accel limit, step time, step count.
//   Input: one transaction on in_valid/in_ready carries a rollout request.
//   in_ready is high only while the sequencer is idle.
//   Output: one transaction per trajectory point on out_valid/out_ready;
//   last_point marks the final one. The point register frees the
//   sequencer: the next step is computed while a point waits.
// Sequence:
//   Start-up forms two limit*dt products and runs the restoring heading
//   wrap, then the first point is registered in the emit state. Each
//   further point takes a CORDIC set-up, 16 CORDIC iterations, five
//   passes through the one 34x34 multiplier, a heading update, a
//   restoring wrap of the heading and an emit. The reset step count is 40.
// Reset: rst_n (synchronous, active low) returns the configuration registers
//   to their reset values, idles the sequencer and drops any pending point.
// Stall: when out_ready is low the point is held; the sequencer stops at its
//   next emit cycle until the register frees.
module accel_limited_unicycle_rollout (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  alur_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alur_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  alur_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]         cfg_data
);
  import alur_pkg::*;

  // Configuration registers
  logic [30:0] lin_lim_r, ang_lim_r;
  logic [16:0] dt_r;
  logic [6:0]  step_cnt_r;

  // Sequencer
  state_t state_r, state_nxt;

  // Rollout state
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [18:0] h_r, h_nxt;
  logic signed [31:0] v_r, v_nxt, w_r, w_nxt, tv_r, tv_nxt, tw_r, tw_nxt;
  logic        [32:0] dv_r, dv_nxt, dw_r, dw_nxt;
  logic signed [33:0] dx_r, dx_nxt;
  logic        [5:0]  idx_r, idx_nxt, last_idx_r, last_idx_nxt;

  // CORDIC
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [35:0] cz_r, cz_nxt;
  logic               neg_r, neg_nxt;
  logic        [4:0]  iter_r, iter_nxt;

  // Heading wrap unit
  logic [35:0] wr_r, wr_nxt;
  logic [3:0]  wk_r, wk_nxt;

  // Shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_r;
  logic signed [67:0] r16_full, r30_full;
  logic signed [33:0] r16, r30;

  // Point register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic               emit_go;
  logic [35:0]        mod_sh, wr_step;
  logic signed [33:0] sh_x, sh_y;
  logic signed [35:0] z0;
  logic signed [33:0] dt_s;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign emit_go  = !out_valid_r || out_ready;
  assign dt_s     = $signed({17'd0, dt_r});
  assign r16_full = (prod_r + 68'sd32768) >>> 16;
  assign r30_full = (prod_r + 68'sd536870912) >>> 30;
  assign r16      = r16_full[33:0];
  assign r30      = r30_full[33:0];
  assign mod_sh   = TWO_PI_Q16 << wk_r;
  assign wr_step  = (wr_r >= mod_sh) ? (wr_r - mod_sh) : wr_r;
  assign sh_x     = cy_r >>> iter_r;
  assign sh_y     = cx_r >>> iter_r;
  assign z0       = 36'(h_r) <<< 14;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_DV;
      ST_DV:     state_nxt = ST_DW;
      ST_DW:     state_nxt = ST_DWL;
      ST_DWL:    state_nxt = ST_WRAP;
      ST_WRAP:   if (wk_r == 4'd0) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_nxt = (idx_r == last_idx_r) ? ST_IDLE : ST_CINIT;
      end
      ST_CINIT:  state_nxt = ST_CORD;
      ST_CORD:   if (iter_r == 5'(CORDIC_N - 1)) state_nxt = ST_MVC;
      ST_MVC:    state_nxt = ST_MVCDT;
      ST_MVCDT:  state_nxt = ST_MVS;
      ST_MVS:    state_nxt = ST_MVSDT;
      ST_MVSDT:  state_nxt = ST_MWDT;
      ST_MWDT:   state_nxt = ST_HW;
      ST_HW:     state_nxt = ST_WRAP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    x_nxt = x_r;  y_nxt = y_r;  h_nxt = h_r;
    v_nxt = v_r;  w_nxt = w_r;  tv_nxt = tv_r;  tw_nxt = tw_r;
    dv_nxt = dv_r;  dw_nxt = dw_r;  dx_nxt = dx_r;
    idx_nxt = idx_r;  last_idx_nxt = last_idx_r;
    cx_nxt = cx_r;  cy_nxt = cy_r;  cz_nxt = cz_r;  neg_nxt = neg_r;  iter_nxt = iter_r;
    wr_nxt = wr_r;  wk_nxt = wk_r;
    mul_a = '0;  mul_b = '0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        x_nxt  = in_data.start_x;
        y_nxt  = in_data.start_y;
        v_nxt  = in_data.start_linear;
        w_nxt  = in_data.start_angular;
        tv_nxt = in_data.target_linear;
        tw_nxt = in_data.target_angular;
        wr_nxt = unsigned'(36'(in_data.start_heading) + PI_Q16 + WRAP_OFS);
        wk_nxt = WRAP_TOP;
        idx_nxt = '0;
        if (step_cnt_r == 7'd0) begin
          last_idx_nxt = '0;
        end else if (step_cnt_r > 7'(MAX_STEPS)) begin
          last_idx_nxt = 6'(MAX_STEPS - 1);
        end else begin
          last_idx_nxt = 6'(step_cnt_r - 7'd1);
        end
      end
      ST_DV: begin
        mul_a = $signed({3'd0, lin_lim_r});
        mul_b = dt_s;
      end
      ST_DW: begin
        dv_nxt = r16[32:0];
        mul_a  = $signed({3'd0, ang_lim_r});
        mul_b  = dt_s;
      end
      ST_DWL: dw_nxt = r16[32:0];
      ST_WRAP: begin
        // Restoring reduction: subtract 2*pi << k when it fits.
        wr_nxt = wr_step;
        wk_nxt = wk_r - 4'd1;
        if (wk_r == 4'd0) h_nxt = 19'(signed'(wr_step) - PI_Q16);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_data_nxt.point_x     = x_r;
          out_data_nxt.point_y     = y_r;
          out_data_nxt.point_index = idx_r;
          out_data_nxt.last_point  = (idx_r == last_idx_r);
          out_valid_nxt = 1'b1;
          idx_nxt = idx_r + 6'd1;
          v_nxt   = ramp(v_r, tv_r, dv_r);
          w_nxt   = ramp(w_r, tw_r, dw_r);
        end
      end
      ST_CINIT: begin
        // Fold the angle into [-pi/2, pi/2]; negate results when folded.
        neg_nxt = 1'b0;
        cz_nxt  = z0;
        if (z0 > HALF_PI_Q30) begin
          cz_nxt  = z0 - PI_Q30;
          neg_nxt = 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
          cz_nxt  = z0 + PI_Q30;
          neg_nxt = 1'b1;
        end
        cx_nxt   = GAIN_Q30;
        cy_nxt   = '0;
        iter_nxt = '0;
      end
      ST_CORD: begin
        if (cz_r >= 0) begin
          cx_nxt = cx_r - sh_x;
          cy_nxt = cy_r + sh_y;
          cz_nxt = cz_r - atan_q30(iter_r);
        end else begin
          cx_nxt = cx_r + sh_x;
          cy_nxt = cy_r - sh_y;
          cz_nxt = cz_r + atan_q30(iter_r);
        end
        iter_nxt = iter_r + 5'd1;
      end
      ST_MVC: begin
        mul_a = 34'(v_r);
        mul_b = neg_r ? -cx_r : cx_r;
      end
      ST_MVCDT: begin
        mul_a = r30;
        mul_b = dt_s;
      end
      ST_MVS: begin
        dx_nxt = r16;
        mul_a  = 34'(v_r);
        mul_b  = neg_r ? -cy_r : cy_r;
      end
      ST_MVSDT: begin
        mul_a = r30;
        mul_b = dt_s;
      end
      ST_MWDT: begin
        x_nxt = sat32(35'(x_r) + 35'(dx_r));
        y_nxt = sat32(35'(y_r) + 35'(r16));
        mul_a = 34'(w_r);
        mul_b = dt_s;
      end
      ST_HW: begin
        wr_nxt = unsigned'(36'(h_r) + 36'(r16) + PI_Q16 + WRAP_OFS);
        wk_nxt = WRAP_TOP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lin_lim_r   <= 31'd163840;
      ang_lim_r   <= 31'd209715;
      dt_r        <= 17'd1638;
      step_cnt_r  <= 7'd40;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LIN_ACCEL:  lin_lim_r  <= cfg_data[30:0];
          REG_ANG_ACCEL:  ang_lim_r  <= cfg_data[30:0];
          REG_STEP_TIME:  dt_r       <= cfg_data[16:0];
          REG_STEP_COUNT: step_cnt_r <= cfg_data[6:0];
        endcase
      end
    end
    // Payload and datapath, no reset
    prod_r     <= mul_a * mul_b;
    out_data_r <= out_data_nxt;
    x_r <= x_nxt;  y_r <= y_nxt;  h_r <= h_nxt;
    v_r <= v_nxt;  w_r <= w_nxt;  tv_r <= tv_nxt;  tw_r <= tw_nxt;
    dv_r <= dv_nxt;  dw_r <= dw_nxt;  dx_r <= dx_nxt;
    idx_r <= idx_nxt;  last_idx_r <= last_idx_nxt;
    cx_r <= cx_nxt;  cy_r <= cy_nxt;  cz_r <= cz_nxt;  neg_r <= neg_nxt;  iter_r <= iter_nxt;
    wr_r <= wr_nxt;  wk_r <= wk_nxt;
  end

endmodule

/* src/alur_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the rollout block and its bind statement.
// Depends on alur_pkg and accel_limited_unicycle_rollout_assert.svh.
`include "accel_limited_unicycle_rollout_assert.svh"

module alur_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input alur_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input alur_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input alur_pkg::cfg_reg_t  cfg_index,
  input logic [31:0]         cfg_data
);
  import alur_pkg::*;

  // Reset drops any pending point and idles the sequencer.
  `ALUR_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid && in_ready, "reset state wrong")
  // A request transaction closes the input.
  `ALUR_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "ready after request")
  // A stalled point holds.
  `ALUR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "point dropped")

endmodule

bind accel_limited_unicycle_rollout alur_checker u_alur_checker (.*);
